[hw/rtl/ffc_pkg.sv]
// Package: op codes, word types and conversion constants for the float format converter
`default_nettype none
package ffc_pkg;

  typedef enum logic [1:0] {
    OP_F32_BF16 = 2'd0,
    OP_BF16_F32 = 2'd1,
    OP_F32_F16  = 2'd2,
    OP_F16_F32  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result;
    logic        last_out;
  } out_word_t;

  localparam logic [15:0] F16_INF  = 16'h7C00;
  localparam logic [15:0] F16_QNAN = 16'h0200;
  localparam logic [7:0]  F32_BIAS = 8'd127;

endpackage
`default_nettype wire

[hw/rtl/ffc_core.sv]
// Combinational conversion datapath for one word
`default_nettype none
module ffc_core (
  input  wire ffc_pkg::in_word_t  in_word,
  output ffc_pkg::out_word_t      out_word
);

  logic [31:0] v;
  logic [31:0] bf_sum;
  logic [15:0] h16;
  logic [31:0] w16;
  logic [31:0] res;

  assign v = in_word.value;
  assign bf_sum = v + 32'h0000_7FFF + {31'd0, v[16]};

  // fp32 -> fp16
  logic        sgn;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [4:0]  sh;        // right shift 14..24 for subnormals
  logic [23:0] sub_q, rem, half, rmask;
  logic [10:0] sub_r;
  logic [15:0] nbase;
  logic [15:0] nrnd;
  logic        nup;

  always_comb begin
    sgn   = v[31];
    bexp  = v[30:23];
    frac  = v[22:0];
    mant  = {1'b1, frac};
    sh    = 5'(8'd126 - bexp);                 // -e-1 for bexp in 102..112
    sub_q = mant >> sh;
    rmask = (24'd1 << sh) - 24'd1;
    rem   = mant & rmask;
    half  = 24'd1 << (sh - 5'd1);
    sub_r = sub_q[10:0];
    if (rem > half || (rem == half && sub_q[0])) sub_r = sub_r + 11'd1;
    nbase = {1'b0, 5'(bexp - 8'd112), frac[22:13]};
    nup   = frac[12] && (frac[11:0] != 12'd0 || nbase[0]);
    nrnd  = nbase + {15'd0, nup};
    if (nrnd >= ffc_pkg::F16_INF) nrnd = ffc_pkg::F16_INF;
    if (bexp == 8'hFF)
      h16 = {sgn, 15'h7C00} | ((frac != 23'd0) ? ffc_pkg::F16_QNAN : 16'd0);
    else if (bexp > 8'd142)
      h16 = {sgn, ffc_pkg::F16_INF[14:0]};
    else if (bexp >= 8'd113)
      h16 = {sgn, nrnd[14:0]};
    else if (bexp >= 8'd102)
      h16 = {sgn, 4'd0, sub_r};
    else
      h16 = {sgn, 15'd0};
  end

  // fp16 -> fp32, leading-one search over ten fraction bits
  logic [4:0]  hexp;
  logic [9:0]  hfrac;
  logic [3:0]  lz;
  logic [9:0]  nfrac;
  always_comb begin
    hexp  = v[14:10];
    hfrac = v[9:0];
    lz    = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hfrac[i]) lz = 4'(10 - i);
    end
    nfrac = 10'(hfrac << lz);
    if (hexp == 5'd0) begin
      if (hfrac == 10'd0) w16 = {v[15], 31'd0};
      else w16 = {v[15], 8'(ffc_pkg::F32_BIAS - 8'd14 - {4'd0, lz}), nfrac, 13'd0};
    end else if (hexp == 5'h1F) begin
      w16 = {v[15], 8'hFF, hfrac, 13'd0};
    end else begin
      w16 = {v[15], 8'({3'd0, hexp} + 8'd112), hfrac, 13'd0};
    end
  end

  always_comb begin
    unique case (ffc_pkg::op_t'(in_word.op))
      ffc_pkg::OP_F32_BF16: res = {16'd0, bf_sum[31:16]};
      ffc_pkg::OP_BF16_F32: res = {v[15:0], 16'd0};
      ffc_pkg::OP_F32_F16:  res = {16'd0, h16};
      ffc_pkg::OP_F16_F32:  res = w16;
      default:              res = 32'd0;
    endcase
  end

  assign out_word.result   = res;
  assign out_word.last_out = in_word.last_in;

endmodule
`default_nettype wire

[hw/rtl/float_format_converter.sv]
// Top level: registered float format converter, one word per cycle
// out_valid follows start through the input register and then the result register.
// Throughput: one word per cycle; busy is never raised.
// Conversion is a single combinational pass between the two registers.
// Reset (synchronous, active low) clears the valid flags; payloads are not reset.
`default_nettype none
module float_format_converter (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire ffc_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output ffc_pkg::out_word_t      out_word
);

  ffc_pkg::in_word_t  in_r;
  ffc_pkg::out_word_t conv;
  ffc_pkg::out_word_t out_r;
  logic               in_vld_r, out_vld_r;

  assign busy = 1'b0;

  ffc_core u_core (.in_word(in_r), .out_word(conv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
    if (start) in_r <= in_word;
    if (in_vld_r) out_r <= conv;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

[hw/rtl/ffc_checker.sv]
// Port-level checker for the float format converter, bound to the top level
`default_nettype none
module ffc_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire ffc_pkg::in_word_t  in_word,
  input wire                     out_valid,
  input wire ffc_pkg::out_word_t out_word
);

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid) else $error("missing result");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 (out_word.last_out == $past(in_word.last_in, 2)))
    else $error("last flag mismatch");

  a_b2f: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.op == ffc_pkg::OP_BF16_F32 |->
      ##2 (out_word.result == {$past(in_word.value[15:0], 2), 16'd0}))
    else $error("bf16 widen mismatch");

  a_hi0: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.op == ffc_pkg::OP_F32_BF16 ||
                       in_word.op == ffc_pkg::OP_F32_F16) |->
      ##2 (out_word.result[31:16] == 16'd0))
    else $error("upper half not zero");

endmodule

bind float_format_converter ffc_checker u_ffc_checker (.*);
`default_nettype wire
